// File: src/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg : shared constants for the sine commutation block
// widths, register indexes and the sine table entry function
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  localparam int unsigned SINE_TABLE_SIZE = 256;
  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_SIZE);
  localparam int unsigned SIZE_W = $clog2(SINE_TABLE_SIZE + 1);

  localparam int unsigned ENC_W      = 16;
  localparam int unsigned POS_W      = 14;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned POLE_W     = 6;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned SINE_W     = 16;
  localparam int unsigned DUTY_W     = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ANGLE_W-1:0] THIRD_TURN = 16'd21845;
  localparam int unsigned DUTY_MID = 5000;
  localparam int unsigned DUTY_MAX = 10000;

  localparam logic [POLE_W-1:0]  POLE_RESET   = 6'd6;
  localparam logic [ANGLE_W-1:0] OFFSET_RESET = 16'd6881;
  localparam logic [MAG_W-1:0]   MAG_RESET    = 16'd19661;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_FACTOR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAGNITUDE = 2'd2;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // one horner step of the quarter-wave taylor series, q30
  function automatic logic [63:0] horner_next(input logic [63:0] term);
    return (term > Q30_ONE) ? 64'd0 : (Q30_ONE - term);
  endfunction

  // sine table entry k in signed q1.15, evaluated at elaboration
  function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] turn;
    logic [63:0] r;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] h;
    logic [63:0] s;
    logic [1:0]  quad;
    logic signed [SINE_W-1:0] v;
    turn  = (64'(k) << 32) / SINE_TABLE_SIZE;
    quad  = turn[31:30];
    r     = turn & (Q30_ONE - 64'd1);
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    theta = (r * HALF_PI_Q30) >> 30;
    t2    = (theta * theta) >> 30;
    h     = Q30_ONE;
    h     = horner_next((((t2 * h) >> 30) / 64'd110));
    h     = horner_next((((t2 * h) >> 30) / 64'd72));
    h     = horner_next((((t2 * h) >> 30) / 64'd42));
    h     = horner_next((((t2 * h) >> 30) / 64'd20));
    h     = horner_next((((t2 * h) >> 30) / 64'd6));
    s     = (((theta * h) >> 30) + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    v = SINE_W'(s);
    return quad[1] ? -v : v;
  endfunction

endpackage

`default_nettype wire

// File: src/sct_ifs.sv
// ----------------------------------------------------------------------------
// sct channel interfaces : valid/ready channels of the commutation block
// encoder input, duty result and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface sct_in_if;
  import sct_pkg::*;
  logic             valid;
  logic             ready;
  logic [ENC_W-1:0] encoder_word;
  modport source (output valid, output encoder_word, input ready);
  modport sink   (input valid, input encoder_word, output ready);
endinterface

interface sct_out_if;
  import sct_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_u;
  logic [DUTY_W-1:0] duty_v;
  logic [DUTY_W-1:0] duty_w;
  modport source (output valid, output duty_u, output duty_v, output duty_w, input ready);
  modport sink   (input valid, input duty_u, input duty_v, input duty_w, output ready);
endinterface

interface sct_cfg_if;
  import sct_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

// File: src/sine_commutation_three_phase_top.sv
// ----------------------------------------------------------------------------
// sine_commutation_three_phase_top : three-phase sine commutation pipeline
// throughput: one item per cycle unless the output stalls; the four stage registers (angle multiply,
// sine table read, magnitude multiply, duty scale) each hold one item
// a stalled output freezes the whole pipeline; nothing is dropped
// reset: synchronous rst_n clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module sine_commutation_three_phase_top (
  input  wire        clk,
  input  wire        rst_n,
  sct_in_if.sink     in_ch,
  sct_out_if.source  out_ch,
  sct_cfg_if.sink    cfg_ch
);
  import sct_pkg::*;

  // configuration registers
  logic [POLE_W-1:0]  pole_factor_r;
  logic [ANGLE_W-1:0] angle_offset_r;
  logic [MAG_W-1:0]   drive_magnitude_r;

  // pipeline valid bits
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic advance;

  // stage payloads, one lane per phase (u, v, w)
  logic [ANGLE_W-1:0]       angle_r, angle_nxt;
  logic signed [SINE_W-1:0] sine_r [3];
  logic signed [SINE_W-1:0] sine_nxt [3];
  logic signed [32:0]       prod_r [3];
  logic signed [32:0]       prod_nxt [3];
  logic [DUTY_W-1:0]        duty_r [3];
  logic [DUTY_W-1:0]        duty_nxt [3];

  // constant sine table, filled at elaboration
  logic signed [SINE_W-1:0] rom_c [SINE_TABLE_SIZE];

  for (genvar g = 0; g < SINE_TABLE_SIZE; g++) begin : g_rom
    assign rom_c[g] = sine_entry(g);
  end

  // the whole pipeline moves when the output slot is free or being taken
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.duty_u = duty_r[0];
  assign out_ch.duty_v = duty_r[1];
  assign out_ch.duty_w = duty_r[2];

  // stage 1: electrical angle = position * pole factor * 4 + offset, mod 2^16
  logic [POS_W+POLE_W-1:0] pos_prod;

  always_comb begin
    pos_prod  = (POS_W+POLE_W)'(in_ch.encoder_word[POS_W-1:0]) *
                (POS_W+POLE_W)'(pole_factor_r);
    angle_nxt = ANGLE_W'({pos_prod, 2'b00}) + angle_offset_r;
  end

  // stage 2: phase angles 0, +1/3, -1/3 turn and table lookup
  logic [ANGLE_W-1:0]        phase [3];
  logic [ANGLE_W+SIZE_W-1:0] idx_prod [3];
  logic [IDX_W-1:0]          idx [3];

  always_comb begin
    phase[0] = angle_r;
    phase[1] = angle_r + THIRD_TURN;
    phase[2] = angle_r - THIRD_TURN;
    for (int i = 0; i < 3; i++) begin
      // index = floor(phase * size / 2^16), always below the table size
      idx_prod[i] = (ANGLE_W+SIZE_W)'(phase[i]) *
                    (ANGLE_W+SIZE_W)'(SINE_TABLE_SIZE);
      idx[i]      = idx_prod[i][ANGLE_W +: IDX_W];
      sine_nxt[i] = rom_c[idx[i]];
    end
  end

  // stage 3: sine times drive magnitude (q1.15 * q0.16)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = 33'(sine_r[i]) * 33'($signed({1'b0, drive_magnitude_r}));
    end
  end

  // stage 4: scale by 5000, add the midpoint, floor and clamp
  logic signed [47:0] num [3];
  logic signed [16:0] quot [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]  = 48'(prod_r[i]) * 48'(DUTY_MID) + (48'(DUTY_MID) <<< 31);
      quot[i] = num[i][47:31];
      if (quot[i] < 17'sd0) begin
        duty_nxt[i] = '0;
      end else if (quot[i] > 17'(DUTY_MAX)) begin
        duty_nxt[i] = DUTY_W'(DUTY_MAX);
      end else begin
        duty_nxt[i] = quot[i][DUTY_W-1:0];
      end
    end
  end

  // configuration writes; unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_factor_r     <= POLE_RESET;
      angle_offset_r    <= OFFSET_RESET;
      drive_magnitude_r <= MAG_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_POLE_FACTOR:     pole_factor_r     <= cfg_ch.data[POLE_W-1:0];
        CFG_ANGLE_OFFSET:    angle_offset_r    <= cfg_ch.data[ANGLE_W-1:0];
        CFG_DRIVE_MAGNITUDE: drive_magnitude_r <= cfg_ch.data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      angle_r <= angle_nxt;
      for (int i = 0; i < 3; i++) begin
        sine_r[i] <= sine_nxt[i];
        prod_r[i] <= prod_nxt[i];
        duty_r[i] <= duty_nxt[i];
      end
    end
  end

  // an accepted item always occupies the first stage next cycle
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted item missing from stage one");

  // a stall freezes every valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(v1_r) && $stable(v2_r) && $stable(v3_r) && out_valid_r))
    else $error("pipeline moved during a stall");

  // an item in the last internal stage reaches the output when it moves
  a_reach_output: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && advance) |=> out_valid_r)
    else $error("item lost before the output register");

  // every delivered duty lies in range
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (duty_r[0] <= 14'(DUTY_MAX) && duty_r[1] <= 14'(DUTY_MAX) &&
                     duty_r[2] <= 14'(DUTY_MAX)))
    else $error("duty out of range");

endmodule

`default_nettype wire
